// ----- rtl/core/lfw_pkg.sv -----
// lfw_pkg: shared widths, register indexes, reset values, controller state
// and the command/status structs of the led fade wipe effect
// no dependencies
package lfw_pkg;

    localparam int TICK_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int LEVEL_W  = 8;
    localparam int INDEX_W  = 6;
    localparam int TDATA_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DVD_W    = TICK_W + LEVEL_W;
    localparam int STEP_W   = 6;

    localparam int DEF_MAX_LEDS = 64;

    localparam logic [STEP_W-1:0] STEPS_FULL  = STEP_W'(TICK_W);
    localparam logic [STEP_W-1:0] STEPS_LEVEL = STEP_W'(LEVEL_W);

    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEGIN_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIPE_UPWARD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_TICK   = 3'd5;

    localparam logic [COUNT_W-1:0] RST_LED_COUNT    = 7'd1;
    localparam logic [LEVEL_W-1:0] RST_BEGIN_LEVEL  = 8'd0;
    localparam logic [LEVEL_W-1:0] RST_END_LEVEL    = 8'd255;
    localparam logic               RST_WIPE_UPWARD  = 1'b0;
    localparam logic [TICK_W-1:0]  RST_RUN_INTERVAL = 32'd1000;
    localparam logic [TICK_W-1:0]  RST_START_TICK   = 32'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SLOT,
        S_CHECK,
        S_POS,
        S_MUL,
        S_LVL_GO,
        S_LVL,
        S_FIRST,
        S_NEXT,
        S_STOP
    } t_state;

    typedef struct packed {
        logic take;
        logic start_slot;
        logic latch_slot;
        logic start_pos;
        logic latch_pos;
        logic mul;
        logic start_lvl;
        logic load_first;
        logic load_next;
        logic load_stop;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic stop;
        logic out_free;
        logic first_last;
        logic next_last;
    } t_status;

endpackage

// ----- rtl/core/led_fade_wipe_effect_top.sv -----
// led_fade_wipe_effect_top: stream wrapper joining controller and datapath
// uses lfw_pkg, lfw_ctrl, lfw_datapath
//
// Each tick beat yields the brightness writes of a fade wipe: the fading LED
// first, then every LED already passed at the end level, the final beat
// flagged by tlast; once the run interval is over, or when the LED count or
// slot time is zero, a tick gives one beat with running low. The shared
// one-bit-per-cycle divider works out the slot, then the position, then the
// level before the first beat of a running tick is loaded; a stopped beat
// follows the slot division alone. Further beats follow back to back when the
// sink keeps up, and the next tick can be taken in the cycle after the last
// beat is loaded. The last beat of a tick may wait in the output register
// while the next tick is taken. Configuration is written at one register per
// beat, any time the block is idle.
module led_fade_wipe_effect_top #(
    parameter int MAX_LEDS = lfw_pkg::DEF_MAX_LEDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lfw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfw_pkg::TICK_W-1:0]      i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lfw_pkg::TICK_W-1:0]      s_axis_tdata,   // tick_now
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lfw_pkg::TDATA_W-1:0]     m_axis_tdata,   // led_index, level, zero pad
    output logic [0:0]                      m_axis_tuser,   // running
    output logic                            m_axis_tlast
);

    lfw_pkg::t_cmd               cmd;
    lfw_pkg::t_status            status;
    logic [lfw_pkg::INDEX_W-1:0] led_index;
    logic [lfw_pkg::LEVEL_W-1:0] level;
    logic                        running;

    assign o_cfg_ready = 1'b1;

    lfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lfw_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tick      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_led_index (led_index),
        .o_level     (level),
        .o_running   (running),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(lfw_pkg::TDATA_W - lfw_pkg::INDEX_W - lfw_pkg::LEVEL_W){1'b0}},
                           level, led_index};
    assign m_axis_tuser = running;

endmodule

// ----- rtl/core/lfw_div.sv -----
// lfw_div: restoring divider, one quotient bit per cycle
// uses lfw_pkg for widths; dividend is left aligned, step count chosen per use
module lfw_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [lfw_pkg::TICK_W-1:0]       i_rem,
    input  logic [lfw_pkg::DVD_W-1:0]        i_dvd,
    input  logic [lfw_pkg::STEP_W-1:0]       i_steps,
    input  logic [lfw_pkg::TICK_W-1:0]       i_divisor,
    output logic                             o_done,
    output logic [lfw_pkg::DVD_W-1:0]        o_quo,
    output logic [lfw_pkg::TICK_W-1:0]       o_rem
);

    localparam logic [lfw_pkg::STEP_W-1:0] STEP_ONE = 1;

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [lfw_pkg::STEP_W-1:0]  r_cnt, n_cnt;
    logic [lfw_pkg::TICK_W-1:0]  r_rem, n_rem;
    logic [lfw_pkg::DVD_W-1:0]   r_quo, n_quo;
    logic [lfw_pkg::TICK_W-1:0]  r_divisor, n_divisor;
    logic [lfw_pkg::TICK_W:0]    trial;
    logic [lfw_pkg::TICK_W:0]    diff;
    logic                        ge;

    assign trial = {r_rem, r_quo[lfw_pkg::DVD_W-1]};
    assign diff  = trial - {1'b0, r_divisor};
    assign ge    = trial >= {1'b0, r_divisor};

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_divisor = r_divisor;
        if (i_start) begin
            n_busy    = 1'b1;
            n_cnt     = i_steps;
            n_rem     = i_rem;
            n_quo     = i_dvd;
            n_divisor = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[lfw_pkg::TICK_W-1:0] : trial[lfw_pkg::TICK_W-1:0];
            n_quo = {r_quo[lfw_pkg::DVD_W-2:0], ge};
            n_cnt = r_cnt - STEP_ONE;
            if (r_cnt == STEP_ONE) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_divisor <= n_divisor;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/lfw_datapath.sv -----
// lfw_datapath: configuration registers, elapsed time, slot/position/level math
// and the output register; uses lfw_pkg and lfw_div
module lfw_datapath #(
    parameter int MAX_LEDS = lfw_pkg::DEF_MAX_LEDS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [lfw_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfw_pkg::TICK_W-1:0]          i_cfg_data,
    input  logic [lfw_pkg::TICK_W-1:0]          i_tick,
    input  lfw_pkg::t_cmd                       i_cmd,
    output lfw_pkg::t_status                    o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [lfw_pkg::INDEX_W-1:0]         o_led_index,
    output logic [lfw_pkg::LEVEL_W-1:0]         o_level,
    output logic                                o_running,
    output logic                                o_last
);

    localparam int CW = lfw_pkg::COUNT_W;
    localparam int TW = lfw_pkg::TICK_W;
    localparam int LW = lfw_pkg::LEVEL_W;
    localparam int DW = lfw_pkg::DVD_W;
    localparam logic [TW-1:0] MAX_U = TW'(MAX_LEDS);
    localparam logic [CW-1:0] MAX_N = CW'(MAX_LEDS);
    localparam logic [CW-1:0] ONE_N = 1;

    logic [CW-1:0] r_led_count;
    logic [LW-1:0] r_begin_level;
    logic [LW-1:0] r_end_level;
    logic          r_wipe_upward;
    logic [TW-1:0] r_run_interval;
    logic [TW-1:0] r_start_tick;

    logic [TW-1:0]   r_elapsed;
    logic [CW-1:0]   r_n;
    logic [TW-1:0]   r_slot;
    logic [CW-1:0]   r_cur;
    logic [TW-1:0]   r_frac;
    logic [DW-1:0]   r_prod;
    logic [CW-1:0]   r_idx;

    logic                         r_out_valid;
    logic [lfw_pkg::INDEX_W-1:0]  r_out_idx;
    logic [LW-1:0]                r_out_lvl;
    logic                         r_out_run;
    logic                         r_out_last;

    logic [CW-1:0]   n_eff;
    logic            div_start;
    logic [TW-1:0]   div_rem_in;
    logic [DW-1:0]   div_dvd_in;
    logic [lfw_pkg::STEP_W-1:0] div_steps;
    logic [TW-1:0]   div_divisor;
    logic            div_done;
    logic [DW-1:0]   div_quo;
    logic [TW-1:0]   div_rem;

    logic [CW-1:0]   n_last;
    logic [CW-1:0]   pos;
    logic [CW-1:0]   cur;
    logic            diff_neg;
    logic [LW-1:0]   abs_diff;
    logic [LW-1:0]   lvl;
    logic [CW-1:0]   nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count    <= lfw_pkg::RST_LED_COUNT;
            r_begin_level  <= lfw_pkg::RST_BEGIN_LEVEL;
            r_end_level    <= lfw_pkg::RST_END_LEVEL;
            r_wipe_upward  <= lfw_pkg::RST_WIPE_UPWARD;
            r_run_interval <= lfw_pkg::RST_RUN_INTERVAL;
            r_start_tick   <= lfw_pkg::RST_START_TICK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lfw_pkg::REG_LED_COUNT:    r_led_count    <= i_cfg_data[CW-1:0];
                lfw_pkg::REG_BEGIN_LEVEL:  r_begin_level  <= i_cfg_data[LW-1:0];
                lfw_pkg::REG_END_LEVEL:    r_end_level    <= i_cfg_data[LW-1:0];
                lfw_pkg::REG_WIPE_UPWARD:  r_wipe_upward  <= i_cfg_data[0];
                lfw_pkg::REG_RUN_INTERVAL: r_run_interval <= i_cfg_data;
                lfw_pkg::REG_START_TICK:   r_start_tick   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // saturate the count to the build limit
    assign n_eff = ({{(TW-CW){1'b0}}, r_led_count} > MAX_U) ? MAX_N : r_led_count;

    always_comb begin
        div_start   = i_cmd.start_slot | i_cmd.start_pos | i_cmd.start_lvl;
        div_rem_in  = '0;
        div_dvd_in  = {r_elapsed, {LW{1'b0}}};
        div_steps   = lfw_pkg::STEPS_FULL;
        div_divisor = r_slot;
        if (i_cmd.start_slot) begin
            div_dvd_in  = {r_run_interval, {LW{1'b0}}};
            div_divisor = {{(TW-CW){1'b0}}, n_eff};
        end else if (i_cmd.start_lvl) begin
            // high part of the product is already below the slot
            div_rem_in = r_prod[DW-1:LW];
            div_dvd_in = {r_prod[LW-1:0], {TW{1'b0}}};
            div_steps  = lfw_pkg::STEPS_LEVEL;
        end
    end

    lfw_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem     (div_rem_in),
        .i_dvd     (div_dvd_in),
        .i_steps   (div_steps),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quo     (div_quo),
        .o_rem     (div_rem)
    );

    assign n_last = r_n - ONE_N;

    always_comb begin
        if (div_quo[TW-1:0] > {{(TW-CW){1'b0}}, n_last}) begin
            pos = n_last;
        end else begin
            pos = div_quo[CW-1:0];
        end
        cur = r_wipe_upward ? pos : (n_last - pos);
    end

    assign diff_neg = r_end_level < r_begin_level;
    assign abs_diff = diff_neg ? (r_begin_level - r_end_level) : (r_end_level - r_begin_level);
    assign lvl      = diff_neg ? (r_begin_level - div_quo[LW-1:0])
                               : (r_begin_level + div_quo[LW-1:0]);
    assign nxt      = r_wipe_upward ? (r_idx - ONE_N) : (r_idx + ONE_N);

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_elapsed <= i_tick - r_start_tick;
            r_n       <= n_eff;
        end
        if (i_cmd.latch_slot) begin
            r_slot <= div_quo[TW-1:0];
        end
        if (i_cmd.latch_pos) begin
            r_cur  <= cur;
            r_frac <= div_rem;
        end
        if (i_cmd.mul) begin
            r_prod <= DW'(r_frac) * DW'(abs_diff);
        end
        if (i_cmd.load_first) begin
            r_idx <= r_cur;
        end else if (i_cmd.load_next) begin
            r_idx <= nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_first || i_cmd.load_next || i_cmd.load_stop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_first) begin
            r_out_idx  <= r_cur[lfw_pkg::INDEX_W-1:0];
            r_out_lvl  <= lvl;
            r_out_run  <= 1'b1;
            r_out_last <= o_status.first_last;
        end else if (i_cmd.load_next) begin
            r_out_idx  <= nxt[lfw_pkg::INDEX_W-1:0];
            r_out_lvl  <= r_end_level;
            r_out_run  <= 1'b1;
            r_out_last <= o_status.next_last;
        end else if (i_cmd.load_stop) begin
            r_out_idx  <= '0;
            r_out_lvl  <= '0;
            r_out_run  <= 1'b0;
            r_out_last <= 1'b1;
        end
    end

    always_comb begin
        o_status.div_done   = div_done;
        o_status.stop       = (r_n == '0) || (r_slot == '0) || (r_elapsed >= r_run_interval);
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.first_last = r_wipe_upward ? (r_cur == '0) : (r_cur == n_last);
        o_status.next_last  = r_wipe_upward ? (nxt == '0) : (nxt == n_last);
    end

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_out_idx;
    assign o_level     = r_out_lvl;
    assign o_running   = r_out_run;
    assign o_last      = r_out_last;

endmodule

// ----- rtl/core/lfw_ctrl.sv -----
// lfw_ctrl: tick sequencer: three divisions, a multiply, then result beats,
// or a stop beat after the slot division; uses lfw_pkg state, command/status types
module lfw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lfw_pkg::t_status  i_status,
    output lfw_pkg::t_cmd     o_cmd
);

    lfw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lfw_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lfw_pkg::S_SLOT;
            end
            lfw_pkg::S_SLOT: begin
                if (i_status.div_done) n_state = lfw_pkg::S_CHECK;
            end
            lfw_pkg::S_CHECK: begin
                n_state = i_status.stop ? lfw_pkg::S_STOP : lfw_pkg::S_POS;
            end
            lfw_pkg::S_POS: begin
                if (i_status.div_done) n_state = lfw_pkg::S_MUL;
            end
            lfw_pkg::S_MUL: begin
                n_state = lfw_pkg::S_LVL_GO;
            end
            lfw_pkg::S_LVL_GO: begin
                n_state = lfw_pkg::S_LVL;
            end
            lfw_pkg::S_LVL: begin
                if (i_status.div_done) n_state = lfw_pkg::S_FIRST;
            end
            lfw_pkg::S_FIRST: begin
                if (i_status.out_free) begin
                    n_state = i_status.first_last ? lfw_pkg::S_IDLE : lfw_pkg::S_NEXT;
                end
            end
            lfw_pkg::S_NEXT: begin
                if (i_status.out_free && i_status.next_last) n_state = lfw_pkg::S_IDLE;
            end
            lfw_pkg::S_STOP: begin
                if (i_status.out_free) n_state = lfw_pkg::S_IDLE;
            end
            default: n_state = lfw_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lfw_pkg::S_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.take       = i_in_valid;
                o_cmd.start_slot = i_in_valid;
            end
            lfw_pkg::S_SLOT:   o_cmd.latch_slot = i_status.div_done;
            lfw_pkg::S_CHECK:  o_cmd.start_pos  = !i_status.stop;
            lfw_pkg::S_POS:    o_cmd.latch_pos  = i_status.div_done;
            lfw_pkg::S_MUL:    o_cmd.mul        = 1'b1;
            lfw_pkg::S_LVL_GO: o_cmd.start_lvl  = 1'b1;
            lfw_pkg::S_LVL:    ;
            lfw_pkg::S_FIRST:  o_cmd.load_first = i_status.out_free;
            lfw_pkg::S_NEXT:   o_cmd.load_next  = i_status.out_free;
            lfw_pkg::S_STOP:   o_cmd.load_stop  = i_status.out_free;
            default: ;
        endcase
    end

endmodule

// ----- rtl/core/lfw_checker.sv -----
// lfw_checker: port-level assertions for the led fade wipe effect
// uses lfw_pkg widths; bound to led_fade_wipe_effect_top below
module lfw_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tready,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [lfw_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  logic [0:0]                      m_axis_tuser,
    input  logic                            m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled beat changed");

    a_stop_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("stopped beat malformed");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a tick's beats");

    a_no_take_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("tick taken before its results were issued");

endmodule

bind led_fade_wipe_effect_top lfw_checker u_lfw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
